[src/pic_pkg.sv]
package pic_pkg;

    // field widths of the item channels
    localparam int COORD_W    = 16;
    localparam int OFF_W      = 24;
    localparam int DEPTH_W    = 24;
    localparam int SLOT_W     = 6;
    localparam int NUM_COORD  = 6;

    // configuration port
    localparam int DIMS_W     = 3;
    localparam int FACES_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // datapath widths: q1.14 times q8.8 gives q.22, offsets scaled up by 2^14
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 40;
    localparam int FRAC_SHIFT = 14;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACES = 1'd1;

    localparam logic [DIMS_W-1:0]  DIMS_RESET  = 3'd3;
    localparam logic [DIMS_W-1:0]  DIMS_MIN    = 3'd2;
    localparam logic [FACES_W-1:0] FACES_RESET = 7'd0;

    // result codes
    localparam logic signed [DEPTH_W-1:0] DEPTH_NONE = '1;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX  = 24'sh7FFFFF;

    // control that travels with each face through the datapath
    typedef struct packed {
        logic vld;
        logic last;
    } t_ctl;

endpackage

[src/pic_in_if.sv]
interface pic_in_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     opcode;
    logic [pic_pkg::SLOT_W-1:0]               face_slot;
    logic signed [pic_pkg::COORD_W-1:0]       coord_a;
    logic signed [pic_pkg::COORD_W-1:0]       coord_b;
    logic signed [pic_pkg::COORD_W-1:0]       coord_c;
    logic signed [pic_pkg::COORD_W-1:0]       coord_d;
    logic signed [pic_pkg::COORD_W-1:0]       coord_e;
    logic signed [pic_pkg::COORD_W-1:0]       coord_f;
    logic signed [pic_pkg::OFF_W-1:0]         plane_offset;

    modport source (
        output valid, opcode, face_slot, coord_a, coord_b, coord_c,
               coord_d, coord_e, coord_f, plane_offset,
        input  ready
    );
    modport sink (
        input  valid, opcode, face_slot, coord_a, coord_b, coord_c,
               coord_d, coord_e, coord_f, plane_offset,
        output ready
    );
endinterface

[src/pic_out_if.sv]
interface pic_out_if;
    logic                               valid;
    logic                               ready;
    logic                               is_inside;
    logic signed [pic_pkg::DEPTH_W-1:0] depth_inside;

    modport source (
        output valid, is_inside, depth_inside,
        input  ready
    );
    modport sink (
        input  valid, is_inside, depth_inside,
        output ready
    );
endinterface

[src/point_in_convex_polytope_core.sv]
// point in convex polytope, half-space test against a table of face planes
//
// i_item carries load and query items, o_item carries one result per query.
// a load writes one face (normal in q1.14, offset in q8.8) into its slot and
// gives no result; loads stream at one per cycle while no query is in
// progress. a query walks faces 0 .. faces_in_use-1, one face per cycle
// through a memory read stage, a product stage, two adder stages and a
// min/compare stage. a query's result is loaded into the output register once
// its last face has passed the min/compare stage and that register is free,
// and the next item can be taken in the cycle after; one query is in flight
// at a time since its walk owns the single read port of the memory. with no
// faces the walk is skipped and the result is marked done on acceptance.
// the output register keeps the result while the receiver stalls; the next
// item is accepted once the result has moved into the output register, and a
// finished result that finds that register still full holds the input off.
// synchronous reset clears control and configuration (dims_in_use 3,
// faces_in_use 0) and holds i_item.ready low; the face tables are not
// cleared and must be loaded before a query walks them.
module point_in_convex_polytope_core #(
    parameter int MAX_FACES = 64,
    parameter int MAX_DIM   = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    pic_in_if.sink                             i_item,
    pic_out_if.source                          o_item,
    input  logic                               i_cfg_we,
    input  logic [pic_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pic_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int FIDX_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int CNT_W  = $clog2(MAX_FACES + 1);
    localparam int LIM_W  = (CNT_W > pic_pkg::FACES_W) ? CNT_W : pic_pkg::FACES_W;
    localparam int Q_W    = pic_pkg::SUM_W - pic_pkg::FRAC_SHIFT;

    // configuration
    logic [pic_pkg::DIMS_W-1:0]          r_cfg_dims;
    logic [pic_pkg::FACES_W-1:0]         r_cfg_faces;

    // face memories
    pic_pkg::t_coord [MAX_DIM-1:0]       r_norm_mem [MAX_FACES];
    logic signed [pic_pkg::OFF_W-1:0]    r_off_mem  [MAX_FACES];

    // walker and read stage
    logic                                r_walk_busy;
    logic [FIDX_W-1:0]                   r_face_idx;
    logic [FIDX_W-1:0]                   r_face_last;
    pic_pkg::t_ctl                       r_rd_ctl;
    pic_pkg::t_coord [MAX_DIM-1:0]       r_rd_norm;
    logic signed [pic_pkg::OFF_W-1:0]    r_rd_off;
    pic_pkg::t_coord [MAX_DIM-1:0]       r_pt;

    // combine stage
    logic                                r_outside;
    logic                                r_any;
    logic                                r_cmb_done;
    pic_pkg::t_sum                       r_best;

    // output register
    logic                                r_out_vld;
    logic                                r_out_inside;
    logic signed [pic_pkg::DEPTH_W-1:0]  r_out_depth;

    pic_pkg::t_coord                     w_coord [pic_pkg::NUM_COORD];
    pic_pkg::t_coord [MAX_DIM-1:0]       w_norm_row;
    pic_pkg::t_coord [MAX_DIM-1:0]       w_pt;
    logic [pic_pkg::DIMS_W-1:0]          w_dims;
    logic [LIM_W-1:0]                    w_faces_lim;
    logic                                w_slot_ok;
    logic                                w_accept;
    logic                                w_load_acc;
    logic                                w_query_acc;
    logic                                w_busy;
    logic                                w_out_free;
    pic_pkg::t_ctl                       w_dot_ctl;
    pic_pkg::t_sum                       w_dot_sum;
    logic                                w_dot_busy;
    pic_pkg::t_sum                       w_neg;
    logic [Q_W-1:0]                      w_q;
    logic signed [pic_pkg::DEPTH_W-1:0]  w_depth;

    // input fields as lanes
    always_comb begin
        w_coord[0] = i_item.coord_a;
        w_coord[1] = i_item.coord_b;
        w_coord[2] = i_item.coord_c;
        w_coord[3] = i_item.coord_d;
        w_coord[4] = i_item.coord_e;
        w_coord[5] = i_item.coord_f;
    end

    // handshake on the input side
    assign w_busy      = r_walk_busy | r_rd_ctl.vld | w_dot_busy | r_cmb_done;
    assign i_item.ready = i_rst_n && !w_busy;
    assign w_accept    = i_item.valid && i_item.ready;
    assign w_load_acc  = w_accept && (i_item.opcode == pic_pkg::OP_LOAD);
    assign w_query_acc = w_accept && (i_item.opcode == pic_pkg::OP_QUERY);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dims  <= pic_pkg::DIMS_RESET;
            r_cfg_faces <= pic_pkg::FACES_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pic_pkg::CFG_DIMS) begin
                r_cfg_dims <= i_cfg_data[pic_pkg::DIMS_W-1:0];
            end
            if (i_cfg_idx == pic_pkg::CFG_FACES) begin
                r_cfg_faces <= i_cfg_data[pic_pkg::FACES_W-1:0];
            end
        end
    end

    // clamped dimension and face counts
    always_comb begin
        if (r_cfg_dims < pic_pkg::DIMS_MIN) begin
            w_dims = pic_pkg::DIMS_MIN;
        end else if (32'(r_cfg_dims) > MAX_DIM) begin
            w_dims = pic_pkg::DIMS_W'(MAX_DIM);
        end else begin
            w_dims = r_cfg_dims;
        end
        if (LIM_W'(r_cfg_faces) > LIM_W'(MAX_FACES)) begin
            w_faces_lim = LIM_W'(MAX_FACES);
        end else begin
            w_faces_lim = LIM_W'(r_cfg_faces);
        end
    end

    // load data and masked query point
    always_comb begin
        for (int d = 0; d < MAX_DIM; d++) begin
            w_norm_row[d] = w_coord[d];
            w_pt[d]       = (d < int'(w_dims)) ? w_coord[d] : '0;
        end
    end

    assign w_slot_ok = 32'(i_item.face_slot) < MAX_FACES;

    // face memory write port
    always_ff @(posedge i_clk) begin
        if (w_load_acc && w_slot_ok) begin
            r_norm_mem[FIDX_W'(i_item.face_slot)] <= w_norm_row;
            r_off_mem[FIDX_W'(i_item.face_slot)]  <= i_item.plane_offset;
        end
    end

    // face memory read port
    always_ff @(posedge i_clk) begin
        r_rd_norm <= r_norm_mem[r_face_idx];
        r_rd_off  <= r_off_mem[r_face_idx];
    end

    // query point held for the whole walk
    always_ff @(posedge i_clk) begin
        if (w_query_acc) begin
            r_pt <= w_pt;
        end
    end

    // face walker, one face per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_busy <= 1'b0;
            r_face_idx  <= '0;
            r_face_last <= '0;
            r_rd_ctl    <= '0;
        end else begin
            r_rd_ctl.vld  <= r_walk_busy;
            r_rd_ctl.last <= r_walk_busy && (r_face_idx == r_face_last);
            if (w_query_acc && (r_cfg_faces != '0)) begin
                r_walk_busy <= 1'b1;
                r_face_idx  <= '0;
                r_face_last <= FIDX_W'(w_faces_lim - LIM_W'(1));
            end else if (r_walk_busy) begin
                r_face_idx <= r_face_idx + FIDX_W'(1);
                if (r_face_idx == r_face_last) begin
                    r_walk_busy <= 1'b0;
                end
            end
        end
    end

    // dot product pipeline
    pic_face_dot #(
        .MAX_DIM (MAX_DIM)
    ) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_norm  (r_rd_norm),
        .i_off   (r_rd_off),
        .i_pt    (r_pt),
        .o_ctl   (w_dot_ctl),
        .o_sum   (w_dot_sum),
        .o_busy  (w_dot_busy)
    );

    assign w_neg      = -w_dot_sum;
    assign w_out_free = !r_out_vld || o_item.ready;

    // combine: sticky outside flag and running minimum of -sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outside  <= 1'b0;
            r_any      <= 1'b0;
            r_cmb_done <= 1'b0;
        end else if (w_query_acc) begin
            r_outside  <= 1'b0;
            r_any      <= 1'b0;
            r_cmb_done <= (r_cfg_faces == '0);
        end else begin
            if (w_dot_ctl.vld && !r_outside) begin
                if (w_dot_sum > 0) begin
                    r_outside <= 1'b1;
                end else if (!r_any || (w_neg < r_best)) begin
                    r_any <= 1'b1;
                end
            end
            if (w_dot_ctl.vld && w_dot_ctl.last) begin
                r_cmb_done <= 1'b1;
            end else if (r_cmb_done && w_out_free) begin
                r_cmb_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dot_ctl.vld && !r_outside && (w_dot_sum <= 0)
            && (!r_any || (w_neg < r_best))) begin
            r_best <= w_neg;
        end
    end

    // depth in q8.8 with saturation
    assign w_q = r_best[pic_pkg::SUM_W-1:pic_pkg::FRAC_SHIFT];

    always_comb begin
        if (r_outside || !r_any) begin
            w_depth = pic_pkg::DEPTH_NONE;
        end else if (w_q > Q_W'(pic_pkg::DEPTH_MAX)) begin
            w_depth = pic_pkg::DEPTH_MAX;
        end else begin
            w_depth = pic_pkg::DEPTH_W'(w_q);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_cmb_done && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_item.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmb_done && w_out_free) begin
            r_out_inside <= !r_outside;
            r_out_depth  <= w_depth;
        end
    end

    assign o_item.valid        = r_out_vld;
    assign o_item.is_inside    = r_out_inside;
    assign o_item.depth_inside = r_out_depth;

endmodule

[src/pic_face_dot.sv]
module pic_face_dot #(
    parameter int MAX_DIM = 6
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pic_pkg::t_ctl                        i_ctl,
    input  pic_pkg::t_coord [MAX_DIM-1:0]        i_norm,
    input  logic signed [pic_pkg::OFF_W-1:0]     i_off,
    input  pic_pkg::t_coord [MAX_DIM-1:0]        i_pt,
    output pic_pkg::t_ctl                        o_ctl,
    output pic_pkg::t_sum                        o_sum,
    output logic                                 o_busy
);

    localparam int HALF = (MAX_DIM + 1) / 2;

    pic_pkg::t_ctl                     r_ctl1;
    pic_pkg::t_ctl                     r_ctl2;
    pic_pkg::t_ctl                     r_ctl3;
    pic_pkg::t_prod [MAX_DIM-1:0]      r_prod;
    logic signed [pic_pkg::OFF_W-1:0]  r_off1;
    pic_pkg::t_sum                     r_sa;
    pic_pkg::t_sum                     r_sb;
    pic_pkg::t_sum                     r_sum;
    pic_pkg::t_sum                     n_sa;
    pic_pkg::t_sum                     n_sb;

    // control stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    // stage 1: one product per lane
    always_ff @(posedge i_clk) begin
        for (int d = 0; d < MAX_DIM; d++) begin
            r_prod[d] <= pic_pkg::t_prod'(i_norm[d]) * pic_pkg::t_prod'(i_pt[d]);
        end
        r_off1 <= i_off;
    end

    // stage 2: two partial sums, offset joins the upper half
    always_comb begin
        n_sa = '0;
        n_sb = pic_pkg::t_sum'(r_off1) <<< pic_pkg::FRAC_SHIFT;
        for (int d = 0; d < HALF; d++) begin
            n_sa = n_sa + pic_pkg::t_sum'($signed(r_prod[d]));
        end
        for (int d = HALF; d < MAX_DIM; d++) begin
            n_sb = n_sb + pic_pkg::t_sum'($signed(r_prod[d]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa <= n_sa;
        r_sb <= n_sb;
    end

    // stage 3: plane sum
    always_ff @(posedge i_clk) begin
        r_sum <= r_sa + r_sb;
    end

    assign o_ctl  = r_ctl3;
    assign o_sum  = r_sum;
    assign o_busy = r_ctl1.vld | r_ctl2.vld | r_ctl3.vld;

endmodule

[src/pic_checker.sv]
module pic_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic                               i_out_inside,
    input  logic signed [pic_pkg::DEPTH_W-1:0] i_out_depth
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_inside) && $stable(i_out_depth))
        else $error("result payload changed while stalled");

    // outside points and negative depths only ever carry the no-depth code
    a_depth_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (!i_out_inside || i_out_depth[pic_pkg::DEPTH_W-1])
        |-> i_out_depth == pic_pkg::DEPTH_NONE)
        else $error("bad depth for outside point");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

endmodule

bind point_in_convex_polytope_core pic_checker u_pic_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_item.valid),
    .i_out_ready  (o_item.ready),
    .i_out_inside (o_item.is_inside),
    .i_out_depth  (o_item.depth_inside)
);

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FACE_SLOTS    = 64;
    localparam int ITEMS_TOTAL   = 550;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_GAP       = 15;

    typedef struct packed {
        logic                                              opcode;
        logic [pic_pkg::SLOT_W-1:0]                        slot;
        logic [pic_pkg::NUM_COORD-1:0][pic_pkg::COORD_W-1:0] coord;
        logic signed [pic_pkg::OFF_W-1:0]                  offset;
    } t_poly_item;

    typedef struct packed {
        logic                               is_inside;
        logic signed [pic_pkg::DEPTH_W-1:0] depth;
    } t_verdict;

    typedef struct packed {
        logic                           is_cfg;
        logic [pic_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [pic_pkg::CFG_DATA_W-1:0] reg_data;
        t_poly_item                     item;
        logic                           typed;
        t_verdict                       want;
    } t_stim_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [pic_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [pic_pkg::CFG_DATA_W-1:0] i_cfg_data;

    pic_in_if  in_ch ();
    pic_out_if out_ch ();

    point_in_convex_polytope_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch),
        .o_item     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // our own copy of the face table and the registers
    pic_pkg::t_coord                  face_normal [FACE_SLOTS][pic_pkg::NUM_COORD];
    logic signed [pic_pkg::OFF_W-1:0] face_offset [FACE_SLOTS];
    logic [pic_pkg::DIMS_W-1:0]       cur_dims;
    logic [pic_pkg::FACES_W-1:0]      cur_faces;

    t_verdict    verdict_q [$];
    t_stim_row   stim_table [$];
    int unsigned mismatches = 0;
    int unsigned item_count = 0;
    bit          tx_gap_on = 1'b1;
    bit          rx_gap_on = 1'b1;
    bit          long_hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    // half-space walk over the faces in use
    function automatic t_verdict judge_point(input t_poly_item it);
        t_verdict res;
        int       nd;
        int       nf;
        longint   s;
        longint   best;
        bit       any;
        nd = int'(cur_dims);
        if (nd < int'(pic_pkg::DIMS_MIN)) nd = int'(pic_pkg::DIMS_MIN);
        if (nd > pic_pkg::NUM_COORD) nd = pic_pkg::NUM_COORD;
        nf = int'(cur_faces);
        if (nf > FACE_SLOTS) nf = FACE_SLOTS;
        res.is_inside = 1'b1;
        res.depth     = pic_pkg::DEPTH_NONE;
        any  = 1'b0;
        best = 0;
        for (int f = 0; f < nf; f++) begin
            s = longint'(face_offset[f]) <<< pic_pkg::FRAC_SHIFT;
            for (int d = 0; d < nd; d++)
                s += longint'(face_normal[f][d]) * longint'(pic_pkg::t_coord'(it.coord[d]));
            // point lies beyond this face, walk stops
            if (s > 0) begin
                res.is_inside = 1'b0;
                res.depth     = pic_pkg::DEPTH_NONE;
                return res;
            end
            if (!any || -s < best) begin
                best = -s;
                any  = 1'b1;
            end
        end
        if (any) begin
            best = best >>> pic_pkg::FRAC_SHIFT;
            res.depth = (best > longint'(pic_pkg::DEPTH_MAX)) ? pic_pkg::DEPTH_MAX
                                                             : pic_pkg::DEPTH_W'(best);
        end
        return res;
    endfunction

    // random load or query item
    function automatic t_poly_item draw_item(input logic op);
        t_poly_item  it;
        int          mag;
        int unsigned sh;
        it.opcode = op;
        it.slot   = pic_pkg::SLOT_W'($urandom);
        it.offset = pic_pkg::OFF_W'($urandom);
        for (int d = 0; d < pic_pkg::NUM_COORD; d++) it.coord[d] = pic_pkg::COORD_W'($urandom);
        if (op == pic_pkg::OP_LOAD && $urandom_range(0, 19) != 0) begin
            // negative offset of a random order of size, so most points sit inside
            sh  = $urandom_range(14, pic_pkg::OFF_W - 1);
            mag = (1 << (sh - 1)) | ($urandom & ((1 << (sh - 1)) - 1));
            it.offset = pic_pkg::OFF_W'(-mag);
        end else if (op == pic_pkg::OP_QUERY && $urandom_range(0, 9) < 6) begin
            // point close to the origin
            sh = $urandom_range(2, 12);
            for (int d = 0; d < pic_pkg::NUM_COORD; d++) begin
                mag = $urandom & ((1 << sh) - 1);
                it.coord[d] = pic_pkg::COORD_W'($urandom_range(0, 1) ? -mag : mag);
            end
        end
        return it;
    endfunction

    function automatic t_stim_row cfg_row(input logic [pic_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [pic_pkg::CFG_DATA_W-1:0] data);
        t_stim_row r;
        r          = '0;
        r.is_cfg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic t_stim_row load_row(
        input logic [pic_pkg::SLOT_W-1:0] slot,
        input logic [pic_pkg::NUM_COORD-1:0][pic_pkg::COORD_W-1:0] nrm,
        input logic [pic_pkg::OFF_W-1:0] off);
        t_stim_row r;
        r             = '0;
        r.item.opcode = pic_pkg::OP_LOAD;
        r.item.slot   = slot;
        r.item.coord  = nrm;
        r.item.offset = off;
        return r;
    endfunction

    // slot and offset carry junk, a query must ignore them
    function automatic t_stim_row query_row(
        input logic [pic_pkg::NUM_COORD-1:0][pic_pkg::COORD_W-1:0] pt,
        input logic typed, input t_verdict want);
        t_stim_row r;
        r             = '0;
        r.item.opcode = pic_pkg::OP_QUERY;
        r.item.slot   = '1;
        r.item.coord  = pt;
        r.item.offset = 24'h5A5A5A;
        r.typed       = typed;
        r.want        = want;
        return r;
    endfunction

    // append one row to the directed table
    function automatic void add_row(input t_stim_row r);
        stim_table.insert(stim_table.size(), r);
    endfunction

    // offer one item, then book it once taken
    task automatic send_item(input t_poly_item it, input bit typed, input t_verdict want);
        int unsigned gap;
        gap = tx_gap_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= it.opcode;
        in_ch.face_slot    <= it.slot;
        in_ch.coord_a      <= it.coord[0];
        in_ch.coord_b      <= it.coord[1];
        in_ch.coord_c      <= it.coord[2];
        in_ch.coord_d      <= it.coord[3];
        in_ch.coord_e      <= it.coord[4];
        in_ch.coord_f      <= it.coord[5];
        in_ch.plane_offset <= it.offset;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        item_count++;
        if (it.opcode == pic_pkg::OP_LOAD) begin
            for (int d = 0; d < pic_pkg::NUM_COORD; d++)
                face_normal[it.slot][d] = pic_pkg::t_coord'(it.coord[d]);
            face_offset[it.slot] = it.offset;
        end else begin
            verdict_q.insert(verdict_q.size(), typed ? want : judge_point(it));
        end
    endtask

    // wait for the block to drain and go quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [pic_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pic_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == pic_pkg::CFG_DIMS) begin
            cur_dims = data[pic_pkg::DIMS_W-1:0];
        end else begin
            cur_faces = data[pic_pkg::FACES_W-1:0];
        end
    endtask

    // stimulus: directed table, table fill, then random phases
    initial begin : stimulus
        t_poly_item                  it;
        int unsigned                 batch;
        int unsigned                 phase;
        logic [pic_pkg::DIMS_W-1:0]  dims_pick;
        logic [pic_pkg::FACES_W-1:0] faces_pick;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= '0;
        i_cfg_data         <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.opcode       <= pic_pkg::OP_LOAD;
        in_ch.face_slot    <= '0;
        in_ch.coord_a      <= '0;
        in_ch.coord_b      <= '0;
        in_ch.coord_c      <= '0;
        in_ch.coord_d      <= '0;
        in_ch.coord_e      <= '0;
        in_ch.coord_f      <= '0;
        in_ch.plane_offset <= '0;
        cur_dims  = pic_pkg::DIMS_RESET;
        cur_faces = pic_pkg::FACES_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no faces after reset
        add_row(query_row({6{16'h8000}}, 1'b1, t_verdict'{1'b1, pic_pkg::DEPTH_NONE}));
        add_row(cfg_row(pic_pkg::CFG_DIMS, 7'd6));
        // most negative offset, depth saturates
        add_row(load_row(6'd0, '0, 24'h800000));
        add_row(cfg_row(pic_pkg::CFG_FACES, 7'd1));
        add_row(query_row({6{16'h7FFF}}, 1'b1, t_verdict'{1'b1, pic_pkg::DEPTH_MAX}));
        // smallest positive offset puts every point outside
        add_row(load_row(6'd0, '0, 24'h000001));
        add_row(query_row({6{16'h8000}}, 1'b1, t_verdict'{1'b0, pic_pkg::DEPTH_NONE}));
        // point on the plane
        add_row(load_row(6'd0, '0, 24'h000000));
        add_row(query_row({6{16'h1234}}, 1'b1, t_verdict'{1'b1, 24'sd0}));
        // extreme normals and points
        add_row(load_row(6'd0, {6{16'h8000}}, 24'h000000));
        add_row(query_row({6{16'h8000}}, 1'b1, t_verdict'{1'b0, pic_pkg::DEPTH_NONE}));
        add_row(query_row({6{16'h7FFF}}, 1'b0, '0));
        add_row(load_row(6'd1, {6{16'h7FFF}}, 24'h7FFFFF));
        add_row(cfg_row(pic_pkg::CFG_FACES, 7'd2));
        add_row(query_row({6{16'h7FFF}}, 1'b0, '0));
        add_row(query_row('0, 1'b0, '0));
        add_row(load_row(6'd1, {16'h0800, 16'hE000, 16'h1000, 16'h2000,
                                16'hC000, 16'h4000}, 24'hFFFF00));
        // dims out of range on both sides
        add_row(cfg_row(pic_pkg::CFG_DIMS, 7'd0));
        add_row(query_row({16'h0300, 16'hFE00, 16'h0100, 16'hFF00,
                           16'h0200, 16'h0100}, 1'b0, '0));
        add_row(cfg_row(pic_pkg::CFG_DIMS, 7'd1));
        add_row(query_row({16'h0300, 16'hFE00, 16'h0100, 16'hFF00,
                           16'h0200, 16'hFD00}, 1'b0, '0));
        add_row(cfg_row(pic_pkg::CFG_DIMS, 7'd7));
        add_row(query_row({16'hFF80, 16'h0040, 16'hFFC0, 16'h0080,
                           16'h0100, 16'hFF00}, 1'b0, '0));
        // unused components must not count
        add_row(load_row(6'd2, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hC000,
                                16'h3000, 16'hF000}, 24'hF00000));
        add_row(cfg_row(pic_pkg::CFG_DIMS, 7'd2));
        add_row(cfg_row(pic_pkg::CFG_FACES, 7'd3));
        add_row(query_row({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                           16'h0010, 16'hFFF0}, 1'b0, '0));
        add_row(load_row(6'd63, {16'h1111, 16'h2222, 16'h3333, 16'h4444,
                                 16'h5555, 16'h6666}, 24'hABCDEF));
        add_row(cfg_row(pic_pkg::CFG_FACES, 7'd0));
        add_row(query_row({6{16'h7FFF}}, 1'b1, t_verdict'{1'b1, pic_pkg::DEPTH_NONE}));
        // upper data bits on the dims register are dropped
        add_row(cfg_row(pic_pkg::CFG_DIMS, 7'h7B));

        foreach (stim_table[i]) begin
            if (stim_table[i].is_cfg) begin
                settle();
                write_reg(stim_table[i].reg_idx, stim_table[i].reg_data);
            end else begin
                send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
            end
        end

        // fill every slot back to back so any face count is legal
        settle();
        tx_gap_on = 1'b0;
        rx_gap_on = 1'b0;
        for (int s = 0; s < FACE_SLOTS; s++) begin
            it      = draw_item(pic_pkg::OP_LOAD);
            it.slot = pic_pkg::SLOT_W'(s);
            send_item(it, 1'b0, '0);
        end

        // random phases, extremes of the registers first
        phase = 0;
        while (item_count < ITEMS_TOTAL) begin
            settle();
            case (phase)
                0: begin
                    dims_pick  = 3'd6;
                    faces_pick = 7'd64;
                end
                1: begin
                    dims_pick  = 3'd2;
                    faces_pick = 7'd1;
                end
                2: begin
                    dims_pick  = 3'd7;
                    faces_pick = 7'd127;
                end
                3: begin
                    dims_pick  = 3'd0;
                    faces_pick = 7'd65;
                end
                4: begin
                    dims_pick  = 3'd1;
                    faces_pick = 7'd0;
                end
                default: begin
                    dims_pick  = pic_pkg::DIMS_W'($urandom_range(0, 7));
                    faces_pick = $urandom_range(0, 1)
                                 ? pic_pkg::FACES_W'($urandom_range(0, 127))
                                 : pic_pkg::FACES_W'($urandom_range(0, FACE_SLOTS));
                end
            endcase
            write_reg(pic_pkg::CFG_DIMS,
                      {(pic_pkg::CFG_DATA_W - pic_pkg::DIMS_W)'($urandom), dims_pick});
            write_reg(pic_pkg::CFG_FACES, faces_pick);
            tx_gap_on = 1'($urandom_range(0, 1));
            rx_gap_on = 1'($urandom_range(0, 1));
            // receiver holds off while items keep coming, so the input backs up
            if (phase == 0) begin
                long_hold_req = 1'b1;
                tx_gap_on     = 1'b0;
            end
            batch = $urandom_range(15, 40);
            repeat (batch)
                send_item(draw_item(($urandom_range(0, 9) < 7) ? pic_pkg::OP_QUERY
                                                               : pic_pkg::OP_LOAD),
                          1'b0, '0);
            phase++;
        end

        settle();
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("PASS point_in_convex_polytope_core");
        end else begin
            $display("FAIL point_in_convex_polytope_core");
        end
        $finish;
    end

    // result side: random stalls, one long hold on request
    initial begin : result_sink
        int unsigned gap;
        t_verdict    want;
        t_verdict    got;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = rx_gap_on ? $urandom_range(0, MAX_GAP) : 0;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                gap           = HOLD_CYCLES;
            end
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            got.is_inside = out_ch.is_inside;
            got.depth     = out_ch.depth_inside;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: inside %0b depth %0d",
                             got.is_inside, got.depth);
            end else begin
                want = verdict_q[0];
                verdict_q.delete(0);
                if (got.is_inside !== want.is_inside || got.depth !== want.depth) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected inside %0b depth %0d, got inside %0b depth %0d",
                                 want.is_inside, want.depth, got.is_inside, got.depth);
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL point_in_convex_polytope_core");
        $finish;
    end

endmodule
